// ===== hw/rtl/masked_four_vector_invariant_mass_top_assert.svh =====
// ----------------------------------------------------------------------------
// masked four-vector invariant mass: assertion macros
// clocked assertions with reset disable, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef MASKED_FOUR_VECTOR_INVARIANT_MASS_TOP_ASSERT_SVH
`define MASKED_FOUR_VECTOR_INVARIANT_MASS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define MVIM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mvim assertion failed");
// condition must never be seen at a clock edge out of reset
`define MVIM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("mvim forbidden condition seen");
`else
`define MVIM_ASSERT(lbl, clk, rstn, prop)
`define MVIM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== hw/rtl/mvim_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvim_pkg
// shared widths, request codes, state encoding and unit status type
// ----------------------------------------------------------------------------
package mvim_pkg;

  localparam int INDEX_BITS = 4;
  localparam int MASK_BITS  = 16;
  localparam int SUM_BITS   = 28;
  localparam int SQ_BITS    = 2 * SUM_BITS + 1;  // signed e^2 - p^2
  localparam int MAG_BITS   = 2 * SUM_BITS;      // magnitude of the above
  localparam int ROOT_BITS  = SUM_BITS;
  localparam int NUM_COMP   = 4;

  // component slots in the sum vector
  localparam int COMP_X = 0;
  localparam int COMP_Y = 1;
  localparam int COMP_Z = 2;
  localparam int COMP_E = 3;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SUM    = 5'b00010,
    S_SQUARE = 5'b00100,
    S_ROOT   = 5'b01000,
    S_OUT    = 5'b10000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mvim_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvim_req_if
// request channel: load of one four-vector or query of a node mask
// ----------------------------------------------------------------------------
interface mvim_req_if import mvim_pkg::*; #(
  parameter int COMPONENT_BITS = 24
) ();

  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic        [INDEX_BITS-1:0]     node_index;
  logic signed [COMPONENT_BITS-1:0] mom_x;
  logic signed [COMPONENT_BITS-1:0] mom_y;
  logic signed [COMPONENT_BITS-1:0] mom_z;
  logic signed [COMPONENT_BITS-1:0] energy_in;
  logic        [MASK_BITS-1:0]      node_mask;

  modport source (
    output valid, req_type, node_index, mom_x, mom_y, mom_z, energy_in, node_mask,
    input  ready
  );

  modport sink (
    input  valid, req_type, node_index, mom_x, mom_y, mom_z, energy_in, node_mask,
    output ready
  );

endinterface

`default_nettype wire

// ===== hw/rtl/mvim_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvim_res_if
// result channel: summed four-vector and invariant mass
// ----------------------------------------------------------------------------
interface mvim_res_if import mvim_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [SUM_BITS-1:0] sum_x;
  logic signed [SUM_BITS-1:0] sum_y;
  logic signed [SUM_BITS-1:0] sum_z;
  logic signed [SUM_BITS-1:0] sum_energy;
  logic        [ROOT_BITS-1:0] mass;

  modport source (
    output valid, sum_x, sum_y, sum_z, sum_energy, mass,
    input  ready
  );

  modport sink (
    input  valid, sum_x, sum_y, sum_z, sum_energy, mass,
    output ready
  );

endinterface

`default_nettype wire

// ===== hw/rtl/mvim_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvim_store
// four-vector table, one write port and one registered read port
// ----------------------------------------------------------------------------
module mvim_store import mvim_pkg::*; #(
  parameter int NODES = 16,
  parameter int WIDTH = 96,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [NODES];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mvim_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvim_accum
// walks the table one entry a cycle and sums the masked four-vectors
// ----------------------------------------------------------------------------
`include "masked_four_vector_invariant_mass_top_assert.svh"

module mvim_accum import mvim_pkg::*; #(
  parameter int NODES          = 16,
  parameter int COMPONENT_BITS = 24,
  parameter int AW             = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [MASK_BITS-1:0]                   node_mask_i,
  output logic                                   rd_en_o,
  output logic [AW-1:0]                          rd_addr_o,
  input  logic [NUM_COMP*COMPONENT_BITS-1:0]     rd_data_i,
  output logic [NUM_COMP-1:0][SUM_BITS-1:0]      sum_o,
  output unit_status_t                           status_o
);

  localparam int WALK = (NODES < MASK_BITS) ? NODES : MASK_BITS;
  localparam int CW   = $clog2(WALK + 1);

  logic                 walking_q;
  logic [CW-1:0]        cnt_q;
  logic [MASK_BITS-1:0] mask_q;
  logic                 pend_q;
  logic                 pend_inc_q;
  logic                 pend_last_q;
  logic                 done_q;
  logic                 last_issue;

  logic signed [COMPONENT_BITS-1:0]     comp [NUM_COMP];
  logic [NUM_COMP-1:0][SUM_BITS-1:0]    comp_w;
  logic [NUM_COMP-1:0][SUM_BITS-1:0]    sum_q;

  assign last_issue = walking_q && (cnt_q == CW'(WALK - 1));
  assign rd_en_o    = walking_q;
  assign rd_addr_o  = AW'(cnt_q);

  // sign-extend each component, then wrap to the sum width
  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      comp[k]   = rd_data_i[k*COMPONENT_BITS +: COMPONENT_BITS];
      comp_w[k] = SUM_BITS'(32'(comp[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q   <= 1'b0;
      cnt_q       <= '0;
      mask_q      <= '0;
      pend_q      <= 1'b0;
      pend_inc_q  <= 1'b0;
      pend_last_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      done_q      <= pend_q && pend_last_q;
      pend_q      <= walking_q;
      pend_inc_q  <= mask_q[0];
      pend_last_q <= last_issue;
      if (start_i) begin
        walking_q <= 1'b1;
        cnt_q     <= '0;
        mask_q    <= node_mask_i;
      end else if (walking_q) begin
        cnt_q  <= cnt_q + CW'(1);
        mask_q <= mask_q >> 1;
        if (last_issue) begin
          walking_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= '0;
    end else if (pend_q && pend_inc_q) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        sum_q[k] <= sum_q[k] + comp_w[k];
      end
    end
  end

  assign sum_o         = sum_q;
  assign status_o.busy = walking_q || pend_q;
  assign status_o.done = done_q;

  `MVIM_ASSERT(a_start_while_free, clk_i, rst_ni, start_i |-> !walking_q && !pend_q)

endmodule

`default_nettype wire

// ===== hw/rtl/mvim_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvim_sqrt
// bit-serial floor square root, one root bit a cycle
// ----------------------------------------------------------------------------
`include "masked_four_vector_invariant_mass_top_assert.svh"

module mvim_sqrt import mvim_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MAG_BITS-1:0]  radicand_i,
  output logic [ROOT_BITS-1:0] root_o,
  output unit_status_t         status_o
);

  localparam int CNT_BITS = $clog2(ROOT_BITS);
  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int TRY_BITS = REM_BITS + 2;

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [MAG_BITS-1:0]  rad_q;
  logic [REM_BITS-1:0]  rem_q;
  logic [ROOT_BITS-1:0] root_q;

  logic [TRY_BITS-1:0]  rem_t;
  logic [TRY_BITS-1:0]  trial;
  logic                 fits;

  assign rem_t = {rem_q, rad_q[MAG_BITS-1 -: 2]};
  assign trial = TRY_BITS'({root_q, 2'b01});
  assign fits  = rem_t >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (fits) begin
        rem_q  <= REM_BITS'(rem_t - trial);
        root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= REM_BITS'(rem_t);
        root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  assign root_o        = root_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

  `MVIM_ASSERT(a_done_ends_run, clk_i, rst_ni, done_q |-> $past(busy_q) && !busy_q)

endmodule

`default_nettype wire

// ===== hw/rtl/masked_four_vector_invariant_mass_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_four_vector_invariant_mass_top
// invariant mass of the summed four-vectors picked out by a node mask
// ----------------------------------------------------------------------------
// A load transfer writes one (px, py, pz, E) entry of the table; it gives no
// result. A query transfer walks the first min(NODES, 16) entries of the
// table through the single read port of the table memory, one entry a cycle,
// adding those whose mask bit is set; then one shared 28x28 multiplier forms
// E^2, px^2, py^2 and pz^2, and a bit-serial unit takes the floor square root
// of |E^2 - p^2| at one bit a cycle, in 28 root steps. One item is in flight
// at a time; the result sits in an output register, so the next transfer is
// taken while it waits. Entries must be loaded before a query selects them;
// loads beyond the table and mask bits beyond it are ignored.
// ----------------------------------------------------------------------------
`include "masked_four_vector_invariant_mass_top_assert.svh"

module masked_four_vector_invariant_mass_top import mvim_pkg::*; #(
  parameter int NODES          = 16,
  parameter int COMPONENT_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvim_req_if.sink   req_i,
  mvim_res_if.source res_o
);

  localparam int AW        = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int ROW_BITS  = NUM_COMP * COMPONENT_BITS;
  localparam int SQC_BITS  = 3;
  localparam int SQ_FINAL  = 5;  // four products accumulated, then the root unit starts

  state_e state_q;

  // request side
  logic                accept;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;
  logic                acc_start;

  // table read port, driven by the walker
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [ROW_BITS-1:0] mem_rdata;

  logic [NUM_COMP-1:0][SUM_BITS-1:0] sums;
  unit_status_t                      acc_status;

  // squaring stage
  logic [SQC_BITS-1:0]          sq_cnt_q;
  logic [1:0]                   sq_sel;
  logic signed [SUM_BITS-1:0]   sq_op;
  logic signed [MAG_BITS-1:0]   prod_q;
  logic signed [SQ_BITS-1:0]    prod_ext;
  logic signed [SQ_BITS-1:0]    acc_q;
  logic signed [SQ_BITS-1:0]    acc_abs;
  logic [MAG_BITS-1:0]          magnitude;

  // root unit
  logic                 sqrt_start;
  logic [ROOT_BITS-1:0] root;
  unit_status_t         sqrt_status;

  // output register
  logic                 res_valid_q;
  logic [SUM_BITS-1:0]  res_x_q;
  logic [SUM_BITS-1:0]  res_y_q;
  logic [SUM_BITS-1:0]  res_z_q;
  logic [SUM_BITS-1:0]  res_e_q;
  logic [ROOT_BITS-1:0] res_mass_q;
  logic                 res_load;

  // ---- request handling ----
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // loads past the end of the table are dropped here
  assign mem_we    = accept && (req_i.req_type == REQ_LOAD)
                     && (32'(req_i.node_index) < NODES);
  assign mem_waddr = AW'(req_i.node_index);
  assign mem_wdata = {req_i.energy_in, req_i.mom_z, req_i.mom_y, req_i.mom_x};
  assign acc_start = accept && (req_i.req_type == REQ_QUERY);

  mvim_store #(
    .NODES (NODES),
    .WIDTH (ROW_BITS),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  mvim_accum #(
    .NODES          (NODES),
    .COMPONENT_BITS (COMPONENT_BITS),
    .AW             (AW)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (acc_start),
    .node_mask_i (req_i.node_mask),
    .rd_en_o     (mem_re),
    .rd_addr_o   (mem_raddr),
    .rd_data_i   (mem_rdata),
    .sum_o       (sums),
    .status_o    (acc_status)
  );

  // ---- squaring: energy first (added), then x, y, z (subtracted) ----
  assign sq_sel   = (sq_cnt_q == '0) ? 2'(COMP_E) : 2'(sq_cnt_q - SQC_BITS'(1));
  assign sq_op    = signed'(sums[sq_sel]);
  assign prod_ext = SQ_BITS'(prod_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_SQUARE) begin
      prod_q <= sq_op * sq_op;
      if (sq_cnt_q == SQC_BITS'(1)) begin
        acc_q <= acc_q + prod_ext;
      end else if (sq_cnt_q != '0 && sq_cnt_q != SQC_BITS'(SQ_FINAL)) begin
        acc_q <= acc_q - prod_ext;
      end
    end else begin
      acc_q <= '0;
    end
  end

  assign acc_abs    = acc_q[SQ_BITS-1] ? -acc_q : acc_q;
  assign magnitude  = acc_abs[MAG_BITS-1:0];
  assign sqrt_start = (state_q == S_SQUARE) && (sq_cnt_q == SQC_BITS'(SQ_FINAL));

  mvim_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (magnitude),
    .root_o     (root),
    .status_o   (sqrt_status)
  );

  // ---- sequencer ----
  assign res_load = (state_q == S_OUT) && (!res_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sq_cnt_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (acc_start) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (acc_status.done) begin
            state_q  <= S_SQUARE;
            sq_cnt_q <= '0;
          end
        end
        S_SQUARE: begin
          sq_cnt_q <= sq_cnt_q + SQC_BITS'(1);
          if (sqrt_start) begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_status.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_x_q    <= sums[COMP_X];
      res_y_q    <= sums[COMP_Y];
      res_z_q    <= sums[COMP_Z];
      res_e_q    <= sums[COMP_E];
      res_mass_q <= root;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.sum_x      = signed'(res_x_q);
  assign res_o.sum_y      = signed'(res_y_q);
  assign res_o.sum_z      = signed'(res_z_q);
  assign res_o.sum_energy = signed'(res_e_q);
  assign res_o.mass       = res_mass_q;

  // table is only written between queries
  `MVIM_ASSERT_NEVER(a_write_outside_idle, clk_i, rst_ni, mem_we && (state_q != S_IDLE))
  // a new result only comes out of the output state
  `MVIM_ASSERT(a_result_from_out, clk_i, rst_ni, $rose(res_valid_q) |-> $past(state_q == S_OUT))
  // the root unit is never restarted mid-run
  `MVIM_ASSERT(a_root_start_free, clk_i, rst_ni, sqrt_start |-> !sqrt_status.busy && !acc_status.busy)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the masked invariant mass block against a predictor of the table
// and of the summed four-vector and mass, over directed and random load/query traffic
// ----------------------------------------------------------------------------
module tb import mvim_pkg::*;;

  localparam int NODES          = 16;
  localparam int COMPONENT_BITS = 24;
  // upper bound on the run, set with wide headroom over the slowest run
  localparam int CYCLE_LIMIT    = 1000000;
  // drain time covers one query plus the longest receiver stall
  localparam int DRAIN_CYCLES   = 120;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int HOLD_OFF_AT    = 100;
  localparam int HOLD_OFF_LEN   = 400;

  localparam logic signed [COMPONENT_BITS-1:0] COMP_MAX = {1'b0, {(COMPONENT_BITS-1){1'b1}}};
  localparam logic signed [COMPONENT_BITS-1:0] COMP_MIN = {1'b1, {(COMPONENT_BITS-1){1'b0}}};

  typedef struct packed {
    logic                             req_type;
    logic        [INDEX_BITS-1:0]     node_index;
    logic signed [COMPONENT_BITS-1:0] mom_x;
    logic signed [COMPONENT_BITS-1:0] mom_y;
    logic signed [COMPONENT_BITS-1:0] mom_z;
    logic signed [COMPONENT_BITS-1:0] energy_in;
    logic        [MASK_BITS-1:0]      node_mask;
  } request_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum_x;
    logic signed [SUM_BITS-1:0] sum_y;
    logic signed [SUM_BITS-1:0] sum_z;
    logic signed [SUM_BITS-1:0] sum_energy;
    logic        [ROOT_BITS-1:0] mass;
  } mass_result_t;

  // clock, reset and everything driven into the block start at known values
  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     drv_valid = 1'b0;
  request_t drv_req   = '0;
  logic     res_ready = 1'b0;

  int unsigned cycle_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned stall_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          held_off = 1'b0;
  int unsigned accepted_count = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned total_items = 0;

  request_t     pending_requests[$];
  mass_result_t expected_mass_results[$];

  // predictor copy of the four-vector store
  logic signed [COMPONENT_BITS-1:0] px_store [NODES];
  logic signed [COMPONENT_BITS-1:0] py_store [NODES];
  logic signed [COMPONENT_BITS-1:0] pz_store [NODES];
  logic signed [COMPONENT_BITS-1:0] e_store  [NODES];

  mvim_req_if #(.COMPONENT_BITS(COMPONENT_BITS)) req_bus ();
  mvim_res_if res_bus ();

  assign req_bus.valid      = drv_valid;
  assign req_bus.req_type   = drv_req.req_type;
  assign req_bus.node_index = drv_req.node_index;
  assign req_bus.mom_x      = drv_req.mom_x;
  assign req_bus.mom_y      = drv_req.mom_y;
  assign req_bus.mom_z      = drv_req.mom_z;
  assign req_bus.energy_in  = drv_req.energy_in;
  assign req_bus.node_mask  = drv_req.node_mask;
  assign res_bus.ready      = res_ready;

  masked_four_vector_invariant_mass_top #(
    .NODES         (NODES),
    .COMPONENT_BITS(COMPONENT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .res_o (res_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // floor square root, one result bit per step from the top
  function automatic logic [ROOT_BITS-1:0] floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[ROOT_BITS-1:0];
  endfunction

  // a load updates the store, a query queues the summed four-vector and mass
  function automatic void predict_four_vector_sum(input request_t r);
    logic signed [SUM_BITS-1:0] acc_x, acc_y, acc_z, acc_e;
    longint sx, sy, sz, se, sq;
    longint unsigned mag;
    mass_result_t res;
    if (r.req_type == REQ_LOAD) begin
      if (r.node_index < NODES) begin
        px_store[r.node_index] = r.mom_x;
        py_store[r.node_index] = r.mom_y;
        pz_store[r.node_index] = r.mom_z;
        e_store[r.node_index]  = r.energy_in;
      end
      return;
    end
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    acc_e = '0;
    // sums wrap at the output width, bits past the table are dropped
    for (int i = 0; i < NODES && i < MASK_BITS; i++) begin
      if (r.node_mask[i]) begin
        acc_x = acc_x + px_store[i];
        acc_y = acc_y + py_store[i];
        acc_z = acc_z + pz_store[i];
        acc_e = acc_e + e_store[i];
      end
    end
    sx = acc_x;
    sy = acc_y;
    sz = acc_z;
    se = acc_e;
    sq = se * se - sx * sx - sy * sy - sz * sz;
    mag = (sq < 0) ? longint'(-sq) : longint'(sq);
    res.sum_x      = acc_x;
    res.sum_y      = acc_y;
    res.sum_z      = acc_z;
    res.sum_energy = acc_e;
    res.mass       = floor_root(mag);
    expected_mass_results.insert(expected_mass_results.size(), res);
  endfunction

  // one stretch in three runs with no idling on either side
  function automatic int unsigned draw_wait();
    if ((cycle_cnt / 3000) % 3 == 0) return 0;
    return $urandom_range(0, 6);
  endfunction

  function automatic logic signed [COMPONENT_BITS-1:0] pick_component();
    int unsigned pick;
    int unsigned raw;
    pick = $urandom_range(0, 7);
    raw  = $urandom;
    case (pick)
      0: return COMP_MAX;
      1: return COMP_MIN;
      2: return COMPONENT_BITS'(int'($urandom_range(0, 2000)) - 1000);
      default: return raw[COMPONENT_BITS-1:0];
    endcase
  endfunction

  task automatic queue_load(input int unsigned idx,
                            input logic signed [COMPONENT_BITS-1:0] x,
                            input logic signed [COMPONENT_BITS-1:0] y,
                            input logic signed [COMPONENT_BITS-1:0] z,
                            input logic signed [COMPONENT_BITS-1:0] e);
    request_t r;
    int unsigned junk;
    junk         = $urandom;
    r.req_type   = REQ_LOAD;
    r.node_index = idx[INDEX_BITS-1:0];
    r.mom_x      = x;
    r.mom_y      = y;
    r.mom_z      = z;
    r.energy_in  = e;
    r.node_mask  = junk[MASK_BITS-1:0];
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic queue_query(input logic [MASK_BITS-1:0] mask);
    request_t r;
    int unsigned junk;
    junk         = $urandom;
    r.req_type   = REQ_QUERY;
    r.node_index = junk[INDEX_BITS-1:0];
    r.mom_x      = pick_component();
    r.mom_y      = pick_component();
    r.mom_z      = pick_component();
    r.energy_in  = pick_component();
    r.node_mask  = mask;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // driver: presents the queued items, predicts each one on its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_req   <= '0;
      send_gap  <= 0;
    end else begin
      if (drv_valid && req_bus.ready) begin
        predict_four_vector_sum(drv_req);
        accepted_count++;
      end
      // the slot is free when nothing is offered or the offer just went through
      if (!drv_valid || req_bus.ready) begin
        if (send_gap != 0) begin
          drv_valid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_requests.size() != 0) begin
          drv_req   <= pending_requests.pop_front();
          drv_valid <= 1'b1;
          send_gap  <= draw_wait();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and drives ready with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned wait_n;
    mass_result_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
      stall_cnt <= 0;
      hold_cnt  <= 0;
      held_off  <= 1'b0;
    end else begin
      wait_n = stall_cnt;
      if (res_bus.valid && res_ready) begin
        if (expected_mass_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected none, actual mass %0d",
                   $time, res_bus.mass);
        end else begin
          want = expected_mass_results.pop_front();
          check_field("sum_x", longint'(want.sum_x), longint'(res_bus.sum_x));
          check_field("sum_y", longint'(want.sum_y), longint'(res_bus.sum_y));
          check_field("sum_z", longint'(want.sum_z), longint'(res_bus.sum_z));
          check_field("sum_energy", longint'(want.sum_energy),
                      longint'(res_bus.sum_energy));
          check_field("mass", longint'(want.mass), longint'(res_bus.mass));
        end
        results_checked++;
        wait_n = draw_wait();
      end
      if (!held_off && results_checked == HOLD_OFF_AT) begin
        // long hold-off so the block fills up and stalls its input
        res_ready <= 1'b0;
        hold_cnt  <= HOLD_OFF_LEN;
        held_off  <= 1'b1;
        stall_cnt <= wait_n;
      end else if (hold_cnt != 0) begin
        res_ready <= 1'b0;
        hold_cnt  <= hold_cnt - 1;
        stall_cnt <= wait_n;
      end else if (wait_n != 0) begin
        res_ready <= 1'b0;
        stall_cnt <= wait_n - 1;
      end else begin
        res_ready <= 1'b1;
        stall_cnt <= 0;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [MASK_BITS-1:0] loaded;
    logic [MASK_BITS-1:0] mask;
    int unsigned idx;
    int unsigned pick;
    int unsigned raw;

    for (int i = 0; i < NODES; i++) begin
      px_store[i] = '0;
      py_store[i] = '0;
      pz_store[i] = '0;
      e_store[i]  = '0;
    end

    // directed: extreme components everywhere, then the corner masks
    queue_load(0, '0, '0, '0, COMP_MAX);       // pure energy, positive mass squared
    queue_load(1, COMP_MAX, '0, '0, '0);       // pure momentum, negative mass squared
    for (int i = 2; i < 8; i++) queue_load(i, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
    for (int i = 8; i < NODES; i++) queue_load(i, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
    queue_query('0);                           // empty mask
    queue_query('1);
    queue_query(16'h0001);
    queue_query(16'h0002);
    queue_query(16'h00FC);
    queue_query(16'hFF00);
    queue_load(0, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
    queue_load(1, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
    queue_query(16'h0003);
    loaded = '1;

    // random: mostly queries over loaded entries, with reloads mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 3) begin
        idx = $urandom_range(0, NODES - 1);
        queue_load(idx, pick_component(), pick_component(), pick_component(),
                   pick_component());
        loaded[idx] = 1'b1;
      end else begin
        pick = $urandom_range(0, 9);
        raw  = $urandom;
        case (pick)
          0: mask = '0;
          1: mask = '1;
          2: mask = MASK_BITS'(1) << $urandom_range(0, MASK_BITS - 1);
          3: mask = raw[MASK_BITS-1:0] & raw[2*MASK_BITS-1:MASK_BITS];
          default: mask = raw[MASK_BITS-1:0];
        endcase
        // never select an entry that was not loaded since reset
        queue_query(mask & loaded);
      end
    end
    total_items = pending_requests.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count != total_items) @(posedge clk_i);
    while (expected_mass_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_mass_results.size() != 0) begin
      mismatches++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               expected_mass_results.size());
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
